// ----- sv/page_replacement_translator_top_assert.svh -----
// Assertion macros for the page replacement translator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PAGE_REPLACEMENT_TRANSLATOR_TOP_ASSERT_SVH
`define PAGE_REPLACEMENT_TRANSLATOR_TOP_ASSERT_SVH

// Property that must hold at every edge out of reset.
`define PGR_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent at one edge implies the consequent at the next.
`define PGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/pgr_pkg.sv -----
// Shared types and constants for the page replacement translator.
// No dependencies.
package pgr_pkg;

  localparam int VADDR_W   = 10;
  localparam int FRAME_W   = 4;
  localparam int OFFSET_W  = 4;
  localparam int PAGE_W    = 6;
  localparam int AGE_W     = 16;
  localparam int NRU_W     = 16;
  localparam int IDX_MAX_W = 8;

  typedef logic [1:0] policy_t;
  localparam policy_t POL_LRU  = 2'd0;
  localparam policy_t POL_NRU  = 2'd1;
  localparam policy_t POL_FIFO = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  typedef struct packed {
    logic                 free_found;
    logic [IDX_MAX_W-1:0] free_idx;
    logic [IDX_MAX_W-1:0] unref_idx;
    logic [IDX_MAX_W-1:0] lru_idx;
  } victim_t;

endpackage

// ----- sv/pgr_if.sv -----
// Valid/ready channel interfaces for access and result beats.
// Depends on pgr_pkg.
interface pgr_in_if import pgr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VADDR_W-1:0] virtual_address;
  logic               is_write;

  modport source (output valid, virtual_address, is_write, input ready);
  modport sink (input valid, virtual_address, is_write, output ready);
endinterface

interface pgr_out_if import pgr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FRAME_W-1:0]  frame_index;
  logic [OFFSET_W-1:0] word_offset;
  logic                page_fault;
  logic                evict_valid;
  logic [PAGE_W-1:0]   evicted_page;
  logic                evict_dirty;

  modport source (output valid, frame_index, word_offset, page_fault, evict_valid,
                  evicted_page, evict_dirty, input ready);
  modport sink (input valid, frame_index, word_offset, page_fault, evict_valid,
                evicted_page, evict_dirty, output ready);
endinterface

// ----- sv/page_replacement_translator_top.sv -----
// Page replacement translator top level: APB registers, page table memory,
// frame state and result register. Depends on pgr_pkg, pgr_if, pgr_victim.
//
// Usage: one access beat on in_ch (virtual_address, is_write) yields exactly
// one result beat on out_ch (frame_index, word_offset, page_fault,
// evict_valid, evicted_page, evict_dirty).
// Each access passes through ST_IDLE, which takes the beat and reads the page
// table memory (registered read), and ST_EXEC, which chooses the victim and
// writes back page table and frame state. The block holds one access at a
// time and takes no new access until ST_EXEC finishes, which it does only
// while the result register is empty or out_ch is ready; the result is then registered.
// When out_ch stalls, the result waits in its register; the next access is
// still taken and waits in ST_EXEC until the register frees up.
// Reset (rst_n low, synchronous) clears all page valid bits and frame state,
// empties the frame queue, and sets the policy to LRU and the NRU period
// to 128. Registers: policy at byte 0, NRU period at byte 4; write them
// only while no access is in flight.
module page_replacement_translator_top import pgr_pkg::*; #(
  parameter int VIRT_PAGES  = 64,
  parameter int PHYS_FRAMES = 16,
  parameter int FRAME_WORDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pgr_in_if.sink      in_ch,
  pgr_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "page_replacement_translator_top_assert.svh"

  localparam int PW  = $clog2(VIRT_PAGES);
  localparam int FRW = (PHYS_FRAMES > 1) ? $clog2(PHYS_FRAMES) : 1;
  localparam int CW  = $clog2(PHYS_FRAMES + 1);

  typedef enum logic [1:0] {ST_IDLE = 2'b01, ST_EXEC = 2'b10} state_t;

  state_t     state_r, state_nxt;
  policy_t    policy_r;
  logic [NRU_W-1:0] period_r;

  logic [PW-1:0]       pg_r;
  logic [OFFSET_W-1:0] off_r;
  logic                wr_r;
  logic [PW-1:0]       page_in;
  logic [OFFSET_W-1:0] off_in;

  logic [FRW-1:0] pf_mem [VIRT_PAGES];
  logic [FRW-1:0] pf_rd_r;
  logic           pf_we;

  logic [VIRT_PAGES-1:0]  pv_r, pv_nxt;
  logic [PHYS_FRAMES-1:0] occ_r, occ_nxt, dirty_r, dirty_nxt, ref_r, ref_nxt;
  logic [PW-1:0]          owner_r [PHYS_FRAMES];
  logic                   owner_we;
  logic [PHYS_FRAMES-1:0][AGE_W-1:0] age_r, age_nxt;
  logic [NRU_W-1:0]       nru_r, nru_nxt;

  logic [FRW-1:0] fifo_mem [PHYS_FRAMES];
  logic           fifo_we;
  logic [FRW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]  fcnt_r, fcnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0]  out_frame_r;
  logic [OFFSET_W-1:0] out_off_r;
  logic                out_fault_r, out_ev_r, out_evd_r;
  logic [PAGE_W-1:0]   out_evp_r;

  victim_t        vic;
  logic           hit, exec_go, ev, evd;
  logic [FRW-1:0] f, vic_idx;
  logic [PW-1:0]  evp;
  logic [AGE_W-1:0] a;
  logic [CW-1:0]  cnt_t;
  logic [NRU_W-1:0] nru_inc;

  logic in_acc, cfg_wr;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_POLICY: prdata = {30'b0, policy_r};
      REG_PERIOD: prdata = {16'b0, period_r};
      default:    prdata = '0;
    endcase
  end

  // ---------------- victim candidates ----------------
  pgr_victim #(.PHYS_FRAMES(PHYS_FRAMES)) u_victim (
    .occupied   (occ_r),
    .referenced (ref_r),
    .age        (age_r),
    .vic        (vic)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign page_in = PW'((32'(in_ch.virtual_address) / FRAME_WORDS) % VIRT_PAGES);
  assign off_in  = OFFSET_W'(32'(in_ch.virtual_address) % FRAME_WORDS);

  assign exec_go = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);
  assign hit     = pv_r[pg_r];

  always_comb begin
    state_nxt     = state_r;
    pv_nxt        = pv_r;
    occ_nxt       = occ_r;
    dirty_nxt     = dirty_r;
    ref_nxt       = ref_r;
    age_nxt       = age_r;
    nru_nxt       = nru_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fcnt_nxt      = fcnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pf_we         = 1'b0;
    owner_we      = 1'b0;
    fifo_we       = 1'b0;
    cnt_t         = fcnt_r;
    a             = '0;
    nru_inc       = nru_r + 1'b1;

    unique case (policy_r)
      POL_NRU: vic_idx = FRW'(vic.unref_idx);
      POL_FIFO: begin
        if (vic.free_found) begin
          vic_idx = FRW'(vic.free_idx);
        end else if (fcnt_r == '0) begin
          vic_idx = '0;
        end else begin
          vic_idx = fifo_mem[head_r];
        end
      end
      default: vic_idx = vic.free_found ? FRW'(vic.free_idx) : FRW'(vic.lru_idx);
    endcase

    f   = hit ? pf_rd_r : vic_idx;
    ev  = !hit && occ_r[f];
    evp = ev ? owner_r[f] : '0;
    evd = ev && dirty_r[f];

    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (exec_go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (hit) begin
            if (wr_r) dirty_nxt[f] = 1'b1;
          end else begin
            if (policy_r == POL_FIFO) begin
              // pop the head when no free frame, then append the victim if the queue has room
              if (!vic.free_found && fcnt_r != '0) begin
                head_nxt = (head_r == FRW'(PHYS_FRAMES - 1)) ? '0 : head_r + 1'b1;
                cnt_t    = fcnt_r - 1'b1;
              end
              if (cnt_t < CW'(PHYS_FRAMES)) begin
                fifo_we  = 1'b1;
                tail_nxt = (tail_r == FRW'(PHYS_FRAMES - 1)) ? '0 : tail_r + 1'b1;
                cnt_t    = cnt_t + 1'b1;
              end
              fcnt_nxt = cnt_t;
            end
            if (ev) pv_nxt[evp] = 1'b0;
            pv_nxt[pg_r] = 1'b1;
            occ_nxt[f]   = 1'b1;
            dirty_nxt[f] = wr_r;
            pf_we        = 1'b1;
            owner_we     = 1'b1;
          end
          ref_nxt[f] = 1'b1;
          if (policy_r == POL_NRU) begin
            nru_nxt = nru_inc;
            if (nru_inc == period_r) begin
              ref_nxt = '0;
              nru_nxt = '0;
            end
          end
          for (int i = 0; i < PHYS_FRAMES; i++) begin
            a = (FRW'(i) == f) ? '0 : age_r[i];
            age_nxt[i] = (a == '1) ? a : a + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // page table memory, registered read
  always_ff @(posedge clk) begin
    if (in_acc) pf_rd_r <= pf_mem[page_in];
    if (pf_we) pf_mem[pg_r] <= f;
  end

  always_ff @(posedge clk) begin
    if (owner_we) owner_r[f] <= pg_r;
    if (fifo_we) fifo_mem[tail_r] <= f;
    if (in_acc) begin
      pg_r  <= page_in;
      off_r <= off_in;
      wr_r  <= in_ch.is_write;
    end
    if (exec_go) begin
      out_frame_r <= FRAME_W'(f);
      out_off_r   <= off_r;
      out_fault_r <= !hit;
      out_ev_r    <= ev;
      out_evp_r   <= PAGE_W'(evp);
      out_evd_r   <= evd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      policy_r    <= POL_LRU;
      period_r    <= NRU_W'(128);
      pv_r        <= '0;
      occ_r       <= '0;
      dirty_r     <= '0;
      ref_r       <= '0;
      age_r       <= '0;
      nru_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      occ_r       <= occ_nxt;
      dirty_r     <= dirty_nxt;
      ref_r       <= ref_nxt;
      age_r       <= age_nxt;
      nru_r       <= nru_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fcnt_r      <= fcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_POLICY: policy_r <= pwdata[1:0];
          REG_PERIOD: period_r <= pwdata[NRU_W-1:0];
          default:    policy_r <= policy_r;
        endcase
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_index  = out_frame_r;
  assign out_ch.word_offset  = out_off_r;
  assign out_ch.page_fault   = out_fault_r;
  assign out_ch.evict_valid  = out_ev_r;
  assign out_ch.evicted_page = out_evp_r;
  assign out_ch.evict_dirty  = out_evd_r;

  `PGR_ASSERT(a_fifo_cnt, fcnt_r <= CW'(PHYS_FRAMES), "frame queue count overflow")
  `PGR_ASSERT(a_ev_fault, !out_valid_r || !out_ev_r || out_fault_r, "eviction without fault")
  `PGR_ASSERT_NEXT(a_load, exec_go && !hit, pv_r[$past(pg_r)], "loaded page not valid")
  `PGR_ASSERT_NEXT(a_acc, in_acc, state_r == ST_EXEC && !in_ch.ready, "access not held")

endmodule

// ----- sv/pgr_victim.sv -----
// Victim candidates: first free frame, first unreferenced frame, oldest frame.
// Depends on pgr_pkg.
module pgr_victim import pgr_pkg::*; #(
  parameter int PHYS_FRAMES = 16
) (
  input  logic [PHYS_FRAMES-1:0]            occupied,
  input  logic [PHYS_FRAMES-1:0]            referenced,
  input  logic [PHYS_FRAMES-1:0][AGE_W-1:0] age,
  output victim_t                           vic
);

  localparam int LV = (PHYS_FRAMES > 1) ? $clog2(PHYS_FRAMES) : 1;
  localparam int NL = 1 << LV;

  logic [AGE_W-1:0]     node_age [2*NL-1];
  logic [IDX_MAX_W-1:0] node_idx [2*NL-1];

  always_comb begin
    vic = '0;
    // scan downward so the lowest index wins
    for (int i = PHYS_FRAMES - 1; i >= 0; i--) begin
      if (!occupied[i]) begin
        vic.free_found = 1'b1;
        vic.free_idx   = IDX_MAX_W'(i);
      end
      if (!referenced[i]) begin
        vic.unref_idx = IDX_MAX_W'(i);
      end
    end
    // max tree, left side wins ties
    for (int i = 0; i < NL; i++) begin
      node_age[NL-1+i] = (i < PHYS_FRAMES) ? age[i] : '0;
      node_idx[NL-1+i] = IDX_MAX_W'(i);
    end
    for (int n = NL - 2; n >= 0; n--) begin
      if (node_age[2*n+1] >= node_age[2*n+2]) begin
        node_age[n] = node_age[2*n+1];
        node_idx[n] = node_idx[2*n+1];
      end else begin
        node_age[n] = node_age[2*n+2];
        node_idx[n] = node_idx[2*n+2];
      end
    end
    vic.lru_idx = node_idx[0];
  end

endmodule

// ----- tb/sv/page_replacement_translator_top_tb.sv -----
// Self-checking bench for the page replacement translator: random and directed
// access beats, policy and period changes, results checked against a predictor.
// Depends on pgr_pkg, pgr_if and the translator top level.
module page_replacement_translator_top_tb;
  import pgr_pkg::*;

  typedef struct packed {
    logic [VADDR_W-1:0] vaddr;
    logic               wr;
  } access_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame;
    logic [OFFSET_W-1:0] offset;
    logic                fault;
    logic                ev;
    logic [PAGE_W-1:0]   evp;
    logic                evd;
  } xlate_t;

  localparam int NPAGE = 64;
  localparam int NFRAME = 16;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  pgr_in_if in_ch ();
  pgr_out_if out_ch ();

  page_replacement_translator_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  policy_t       cur_policy;
  logic [15:0]   cur_period;
  logic          pv_valid [NPAGE];
  logic [3:0]    pv_frame [NPAGE];
  logic          fr_occ [NFRAME];
  logic          fr_dirty [NFRAME];
  logic          fr_ref [NFRAME];
  logic [5:0]    fr_owner [NFRAME];
  logic [15:0]   fr_age [NFRAME];
  logic [15:0]   ref_count;
  logic [3:0]    q_order [NFRAME];
  logic [3:0]    q_head, q_tail;
  int            q_count;

  access_t pending_accesses[$];
  xlate_t  expected_xlates[$];
  int      errors;
  int      burst_left, gap_left;
  int      stall_phase;

  function automatic xlate_t translate(access_t a);
    xlate_t r;
    logic [5:0] page;
    logic [3:0] f;
    int i;
    int top;
    bit found;
    page = a.vaddr[9:4];
    r = '0;
    r.offset = a.vaddr[3:0];
    if (pv_valid[page]) begin
      f = pv_frame[page];
      if (a.wr) fr_dirty[f] = 1'b1;
    end else begin
      r.fault = 1'b1;
      f = '0;
      found = 0;
      if (cur_policy == POL_NRU) begin
        for (i = 0; i < NFRAME; i++)
          if (!found && !fr_ref[i]) begin f = 4'(i); found = 1; end
      end else begin
        for (i = 0; i < NFRAME; i++)
          if (!found && !fr_occ[i]) begin f = 4'(i); found = 1; end
        if (!found && cur_policy == POL_FIFO) begin
          if (q_count != 0) begin
            f = q_order[q_head];
            q_head++;
            q_count--;
          end
        end else if (!found) begin
          top = 0;
          for (i = 0; i < NFRAME; i++)
            if (int'(fr_age[i]) > top) begin top = int'(fr_age[i]); f = 4'(i); end
        end
        if (cur_policy == POL_FIFO && q_count < NFRAME) begin
          q_order[q_tail] = f;
          q_tail++;
          q_count++;
        end
      end
      if (fr_occ[f]) begin
        r.ev = 1'b1;
        r.evp = fr_owner[f];
        r.evd = fr_dirty[f];
        pv_valid[fr_owner[f]] = 1'b0;
      end
      fr_occ[f] = 1'b1;
      fr_owner[f] = page;
      fr_dirty[f] = a.wr;
      pv_valid[page] = 1'b1;
      pv_frame[page] = f;
    end
    fr_ref[f] = 1'b1;
    fr_age[f] = '0;
    if (cur_policy == POL_NRU) begin
      ref_count++;
      if (ref_count == cur_period) begin
        for (i = 0; i < NFRAME; i++) fr_ref[i] = 1'b0;
        ref_count = '0;
      end
    end
    for (i = 0; i < NFRAME; i++)
      if (fr_age[i] != 16'hFFFF) fr_age[i]++;
    r.frame = f;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      // drop the accepted beat; the front is then the next one to send
      if (in_ch.valid) void'(pending_accesses.pop_front());
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_accesses.size() > 0) begin
        access_t nxt;
        nxt = pending_accesses[0];
        in_ch.valid <= 1'b1;
        in_ch.virtual_address <= nxt.vaddr;
        in_ch.is_write <= nxt.wr;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: predict at accepted input beat, check at accepted output beat
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_xlates.push_back(translate('{in_ch.virtual_address, in_ch.is_write}));
      if (out_ch.valid && out_ch.ready) begin
        xlate_t got, exp_r;
        got = '{out_ch.frame_index, out_ch.word_offset, out_ch.page_fault,
                out_ch.evict_valid, out_ch.evicted_page, out_ch.evict_dirty};
        if (expected_xlates.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat expected none actual %h", $time, got);
        end else begin
          exp_r = expected_xlates.pop_front();
          if (got.frame !== exp_r.frame || got.offset !== exp_r.offset ||
              got.fault !== exp_r.fault || got.ev !== exp_r.ev ||
              got.evp !== exp_r.evp || got.evd !== exp_r.evd) begin
            errors++;
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
          end
        end
      end
      // stall pattern: long open stretches, then periodic choking, then random choking
      stall_phase <= stall_phase + 1;
      if (stall_phase[8]) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else if (stall_phase[7]) out_ch.ready <= stall_phase[2:0] != 3'd5;
      else out_ch.ready <= 1'b1;
    end
  end

  task automatic wait_drained();
    while (pending_accesses.size() != 0 || in_ch.valid || expected_xlates.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic reg_write(logic regsel, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {regsel, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (regsel == REG_POLICY) cur_policy = val[1:0];
    else cur_period = val[15:0];
  endtask

  // mostly a working set of a few hot pages, sometimes anywhere
  task automatic add_random(int n, int hot);
    access_t a;
    int base;
    base = $urandom_range(0, 63);
    for (int i = 0; i < n; i++) begin
      a.vaddr = 10'($urandom_range(0, 1023));
      if ($urandom_range(0, 3) != 0)
        a.vaddr[9:4] = 6'((base + $urandom_range(0, hot - 1)) % NPAGE);
      a.wr = 1'($urandom_range(0, 1));
      pending_accesses.push_back(a);
    end
  endtask

  initial begin
    errors = 0;
    rst_n = 1'b0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_ch.valid = 0; in_ch.virtual_address = 0; in_ch.is_write = 0;
    out_ch.ready = 0;
    cur_policy = POL_LRU; cur_period = 128; ref_count = 0;
    q_head = 0; q_tail = 0; q_count = 0;
    for (int i = 0; i < NPAGE; i++) begin pv_valid[i] = 0; pv_frame[i] = 0; end
    for (int i = 0; i < NFRAME; i++) begin
      fr_occ[i] = 0; fr_dirty[i] = 0; fr_ref[i] = 0; fr_owner[i] = 0;
      fr_age[i] = 0; q_order[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, fill all frames, evict dirty under default LRU
    pending_accesses.push_back('{10'd0, 1'b0});
    pending_accesses.push_back('{10'd1023, 1'b1});
    pending_accesses.push_back('{10'd15, 1'b1});
    pending_accesses.push_back('{10'd1008, 1'b0});
    for (int p = 1; p < 20; p++)
      pending_accesses.push_back('{10'(p * 16 + p % 16), p[0]});
    wait_drained();

    // policy value three acts as LRU
    reg_write(REG_POLICY, 32'd3);
    add_random(60, 24);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 3)
        0: reg_write(REG_POLICY, 32'(POL_LRU));
        1: reg_write(REG_POLICY, 32'(POL_NRU));
        default: reg_write(REG_POLICY, 32'(POL_FIFO));
      endcase
      case (ph)
        1: reg_write(REG_PERIOD, 32'd1);
        4: reg_write(REG_PERIOD, 32'd65535);
        7: reg_write(REG_PERIOD, 32'd0);
        10: reg_write(REG_PERIOD, 32'd3);
        default: if (ph % 3 == 1) reg_write(REG_PERIOD, $urandom_range(2, 40));
      endcase
      add_random(115, (ph % 2) ? 20 : 40);
      wait_drained();
    end
    if (errors == 0) $display("page_replacement_translator_top_tb: PASS");
    else $display("page_replacement_translator_top_tb: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("page_replacement_translator_top_tb: FAIL");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/pgr_pkg.sv
sv/pgr_if.sv
sv/pgr_victim.sv
sv/page_replacement_translator_top.sv
tb/sv/page_replacement_translator_top_tb.sv
